FILE: rtl/core/rsp_pkg.sv
`default_nettype none

package rsp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 4;
  localparam int ROW_NUM_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_OPERATION      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLES_IN_USE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTHS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_ZERO    = 3'd3;

  // Operation codes. Codes above OP_ANY are unused and never match.
  localparam logic [2:0] OP_PREFIX   = 3'd0;
  localparam logic [2:0] OP_SUFFIX   = 3'd1;
  localparam logic [2:0] OP_CONTAINS = 3'd2;
  localparam logic [2:0] OP_ORDERED  = 3'd3;
  localparam logic [2:0] OP_ANY      = 3'd4;

  typedef struct packed {
    logic                 row_match;
    logic [ROW_NUM_W-1:0] row_number;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsp_cell.sv
`default_nettype none

// One byte of the tail window. The cell compares the byte that the window
// holds for the current word against one needle byte per needle.
module rsp_cell #(
  parameter int NEEDLES = 4
) (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic                       take,
  input  wire logic [7:0]                 left_byte,
  input  wire logic [NEEDLES-1:0][7:0]    cmp_bytes,
  output logic      [7:0]                 held_byte,
  output logic      [NEEDLES-1:0]         eq
);

  logic [7:0] eff_byte;

  // A word that carries a byte sees the shifted window; an empty-row word
  // sees the window as it stands.
  assign eff_byte = take ? left_byte : held_byte;

  always_comb begin
    for (int k = 0; k < NEEDLES; k++) begin
      eq[k] = (eff_byte == cmp_bytes[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held_byte <= left_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsp_out_queue.sv
`default_nettype none

// Two-entry result queue: a head register and a skid register.
module rsp_out_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rsp_pkg::result_t push_word,
  output logic                 push_ready,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output rsp_pkg::result_t     pop_word
);

  rsp_pkg::result_t head;
  rsp_pkg::result_t spare;
  logic             head_valid;
  logic             spare_valid;

  assign push_ready = !spare_valid;
  assign pop_valid  = head_valid;
  assign pop_word   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!head_valid || pop_ready) begin
      if (spare_valid) begin
        head        <= spare;
        head_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        head_valid <= push;
        if (push) begin
          head <= push_word;
        end
      end
    end else if (push) begin
      spare       <= push_word;
      spare_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/row_substring_predicate_top.sv
// Row substring predicate.
// Input channel (in_valid / in_ready): one word per row byte in data_byte,
// with row_end on the last byte of a row, or a word with empty_row set that
// finishes the row without adding a byte (a zero-length row when no bytes
// came before it). Output channel (out_valid / out_ready): one word per
// finished row carrying row_match and row_number.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// per clock: operation, needles in use, needle lengths, then four needles.
// Throughput is one input word per cycle while in_ready is high; every
// needle is compared against a chain of MAX_NEEDLE_LEN byte cells in
// parallel as each byte enters. The result of a row-finishing word is
// registered in the output queue before it appears on the output.
// When the receiver stalls, one result waits in the output register and a
// second in a skid register; in_ready drops only while the skid register
// is full. Reset (rst, synchronous) empties both, restores the register
// defaults (contains, one needle, all needles empty) and restarts row
// numbering at zero.
`default_nettype none

module row_substring_predicate_top #(
  parameter int MAX_NEEDLES    = 4,
  parameter int MAX_NEEDLE_LEN = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [rsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            row_end,
  input  wire logic                            empty_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 row_match,
  output logic [rsp_pkg::ROW_NUM_W-1:0]        row_number
);

  localparam int CNT_W = $clog2(MAX_NEEDLE_LEN + 1);
  localparam int STG_W = $clog2(MAX_NEEDLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEEDLE_LEN);
  localparam logic [rsp_pkg::LEN_W-1:0] LEN_MAX = rsp_pkg::LEN_W'(MAX_NEEDLE_LEN);
  localparam logic [2:0] NEEDLES_MAX = 3'(MAX_NEEDLES);

  // Configuration registers.
  logic [2:0] operation;
  logic [2:0] needles_in_use;
  logic [MAX_NEEDLES-1:0][rsp_pkg::LEN_W-1:0] needle_len;
  logic [MAX_NEEDLES-1:0][MAX_NEEDLE_LEN-1:0][7:0] needle;

  // Row state.
  logic [CNT_W-1:0] bytes_in_row;
  logic [CNT_W-1:0] bytes_since_anchor;
  logic [STG_W-1:0] needle_stage;
  logic             prefix_still_ok;
  logic             found_any;
  logic [rsp_pkg::ROW_NUM_W-1:0] row_counter;

  logic fire;
  logic take;
  logic finish;
  logic [2:0] needles_used;

  logic [7:0] win [MAX_NEEDLE_LEN];
  logic [7:0] left [MAX_NEEDLE_LEN];
  logic [MAX_NEEDLES-1:0][7:0] cmp [MAX_NEEDLE_LEN];
  logic [MAX_NEEDLES-1:0] eq [MAX_NEEDLE_LEN];

  logic [MAX_NEEDLES-1:0] core_hit;
  logic [MAX_NEEDLES-1:0] hit_row;
  logic [MAX_NEEDLES-1:0] hit_anchor;

  logic [CNT_W-1:0] bytes_in_row_next;
  logic [CNT_W-1:0] bytes_since_anchor_inc;
  logic [CNT_W-1:0] bytes_since_anchor_next;
  logic [STG_W-1:0] stage_skipped;
  logic [STG_W-1:0] needle_stage_next;
  logic             stage_hit;
  logic [7:0]       prefix_byte;
  logic             prefix_still_ok_next;
  logic             found_any_next;
  logic             any_empty;
  logic             verdict;
  logic             queue_ready;
  rsp_pkg::result_t push_word;
  rsp_pkg::result_t out_word;

  // Position of the first needle at or after stage s that is in use and not
  // empty; empty needles pass at once.
  function automatic logic [STG_W-1:0] skip_empty(
    input logic [STG_W-1:0] s,
    input logic [2:0] cnt,
    input logic [MAX_NEEDLES-1:0][rsp_pkg::LEN_W-1:0] lens
  );
    logic [STG_W-1:0] res;
    res = (3'(s) >= cnt) ? s : STG_W'(cnt);
    for (int k = MAX_NEEDLES - 1; k >= 0; k--) begin
      if (k >= int'(s) && k < int'(cnt) && lens[k] != '0) begin
        res = STG_W'(k);
      end
    end
    return res;
  endfunction

  assign fire         = in_valid && in_ready;
  assign take         = !empty_row;
  assign finish       = empty_row || row_end;
  assign in_ready     = queue_ready;
  assign needles_used = (needles_in_use > NEEDLES_MAX) ? NEEDLES_MAX : needles_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation      <= rsp_pkg::OP_CONTAINS;
      needles_in_use <= 3'd1;
      needle_len     <= '0;
      needle         <= '0;
    end else if (cfg_write) begin
      if (cfg_index == rsp_pkg::REG_OPERATION) begin
        operation <= cfg_data[2:0];
      end
      if (cfg_index == rsp_pkg::REG_NEEDLES_IN_USE) begin
        needles_in_use <= cfg_data[2:0];
      end
      if (cfg_index == rsp_pkg::REG_NEEDLE_LENGTHS) begin
        for (int k = 0; k < MAX_NEEDLES; k++) begin
          needle_len[k] <= cfg_data[rsp_pkg::LEN_W*k +: rsp_pkg::LEN_W];
        end
      end
      for (int k = 0; k < MAX_NEEDLES; k++) begin
        if (cfg_index == rsp_pkg::CFG_INDEX_W'(int'(rsp_pkg::REG_NEEDLE_ZERO) + k)) begin
          needle[k] <= cfg_data[8*MAX_NEEDLE_LEN-1:0];
        end
      end
    end
  end

  // Cell i holds the byte i places back from the newest. For a needle of
  // length L it must equal needle byte L-1-i.
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE_LEN; i++) begin
      for (int k = 0; k < MAX_NEEDLES; k++) begin
        cmp[i][k] = '0;
        for (int j = 0; j < MAX_NEEDLE_LEN; j++) begin
          if (int'(needle_len[k]) == i + 1 + j) begin
            cmp[i][k] = needle[k][j];
          end
        end
      end
    end
  end

  for (genvar i = 0; i < MAX_NEEDLE_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i] = data_byte;
    end else begin : g_link
      assign left[i] = win[i-1];
    end

    rsp_cell #(
      .NEEDLES (MAX_NEEDLES)
    ) u_cell (
      .clk       (clk),
      .shift     (fire && take),
      .take      (take),
      .left_byte (left[i]),
      .cmp_bytes (cmp[i]),
      .held_byte (win[i]),
      .eq        (eq[i])
    );
  end

  assign bytes_in_row_next =
    (take && bytes_in_row != CNT_MAX) ? bytes_in_row + CNT_W'(1) : bytes_in_row;
  assign bytes_since_anchor_inc =
    (take && bytes_since_anchor != CNT_MAX) ? bytes_since_anchor + CNT_W'(1)
                                            : bytes_since_anchor;

  always_comb begin
    for (int k = 0; k < MAX_NEEDLES; k++) begin
      core_hit[k] = (needle_len[k] != '0) && (needle_len[k] <= LEN_MAX);
      for (int i = 0; i < MAX_NEEDLE_LEN; i++) begin
        if (i < int'(needle_len[k]) && !eq[i][k]) begin
          core_hit[k] = 1'b0;
        end
      end
      hit_row[k]    = core_hit[k] &&
                      (rsp_pkg::LEN_W'(bytes_in_row_next) >= needle_len[k]);
      hit_anchor[k] = core_hit[k] &&
                      (rsp_pkg::LEN_W'(bytes_since_anchor_inc) >= needle_len[k]);
    end
  end

  always_comb begin
    stage_skipped = skip_empty(needle_stage, needles_used, needle_len);
    stage_hit     = 1'b0;
    for (int k = 0; k < MAX_NEEDLES; k++) begin
      if (int'(stage_skipped) == k && k < int'(needles_used)) begin
        stage_hit = hit_anchor[k];
      end
    end

    prefix_byte = '0;
    for (int j = 0; j < MAX_NEEDLE_LEN; j++) begin
      if (int'(bytes_in_row) == j) begin
        prefix_byte = needle[0][j];
      end
    end

    prefix_still_ok_next = prefix_still_ok;
    if (take && operation == rsp_pkg::OP_PREFIX &&
        rsp_pkg::LEN_W'(bytes_in_row) < needle_len[0] &&
        bytes_in_row < CNT_MAX && prefix_byte != data_byte) begin
      prefix_still_ok_next = 1'b0;
    end

    found_any_next = found_any;
    if (take && operation == rsp_pkg::OP_CONTAINS && hit_row[0]) begin
      found_any_next = 1'b1;
    end
    if (take && operation == rsp_pkg::OP_ANY) begin
      for (int k = 0; k < MAX_NEEDLES; k++) begin
        if (k < int'(needles_used) && hit_row[k]) begin
          found_any_next = 1'b1;
        end
      end
    end

    needle_stage_next       = needle_stage;
    bytes_since_anchor_next = bytes_since_anchor_inc;
    if (take && operation == rsp_pkg::OP_ORDERED) begin
      needle_stage_next = stage_skipped;
      if (3'(stage_skipped) < needles_used && stage_hit) begin
        needle_stage_next       = stage_skipped + STG_W'(1);
        bytes_since_anchor_next = '0;
      end
    end

    any_empty = 1'b0;
    for (int k = 0; k < MAX_NEEDLES; k++) begin
      if (k < int'(needles_used) && needle_len[k] == '0) begin
        any_empty = 1'b1;
      end
    end

    unique case (operation)
      rsp_pkg::OP_PREFIX: begin
        verdict = (needle_len[0] <= LEN_MAX) && prefix_still_ok_next &&
                  (rsp_pkg::LEN_W'(bytes_in_row_next) >= needle_len[0]);
      end
      rsp_pkg::OP_SUFFIX: begin
        verdict = hit_row[0] || (needle_len[0] == '0);
      end
      rsp_pkg::OP_CONTAINS: begin
        verdict = found_any_next || (needle_len[0] == '0);
      end
      rsp_pkg::OP_ORDERED: begin
        verdict = 3'(skip_empty(needle_stage_next, needles_used, needle_len))
                  >= needles_used;
      end
      rsp_pkg::OP_ANY: begin
        verdict = any_empty || found_any_next;
      end
      default: begin
        verdict = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_row       <= '0;
      bytes_since_anchor <= '0;
      needle_stage       <= '0;
      prefix_still_ok    <= 1'b1;
      found_any          <= 1'b0;
      row_counter        <= '0;
    end else if (fire) begin
      if (finish) begin
        bytes_in_row       <= '0;
        bytes_since_anchor <= '0;
        needle_stage       <= '0;
        prefix_still_ok    <= 1'b1;
        found_any          <= 1'b0;
        row_counter        <= row_counter + rsp_pkg::ROW_NUM_W'(1);
      end else begin
        bytes_in_row       <= bytes_in_row_next;
        bytes_since_anchor <= bytes_since_anchor_next;
        needle_stage       <= needle_stage_next;
        prefix_still_ok    <= prefix_still_ok_next;
        found_any          <= found_any_next;
      end
    end
  end

  assign push_word.row_match  = verdict;
  assign push_word.row_number = row_counter;

  rsp_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire && finish),
    .push_word  (push_word),
    .push_ready (queue_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_word   (out_word)
  );

  assign row_match  = out_word.row_match;
  assign row_number = out_word.row_number;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NEEDLES      = 4;
  localparam int NEEDLE_BYTES = 8;
  localparam int RANDOM_WORDS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] OP_CODE_LAST = 3'd7;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
    int         gap;
  } word_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [rsp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid = 1'b0;
  wire                             in_ready;
  wire [7:0]                       data_byte;
  wire                             row_end;
  wire                             empty_row;
  wire                             out_valid;
  logic                            out_ready = 1'b0;
  wire                             row_match;
  wire [rsp_pkg::ROW_NUM_W-1:0]    row_number;

  // Mirror of the configuration registers.
  logic [2:0]  cfg_op;
  logic [2:0]  cfg_count;
  logic [15:0] cfg_lens;
  logic [63:0] cfg_needle [NEEDLES];

  // Mirror of the per-row matching state.
  logic [7:0]     recent [NEEDLE_BYTES];
  int             row_len;
  int             anchor_gap;
  int             stage;
  bit             prefix_ok;
  bit             hit;
  logic [31:0]    row_index;

  word_t            words_to_send [$];
  rsp_pkg::result_t rows_due [$];
  word_t            cur_word = '{8'h00, 1'b0, 1'b0, 0};
  bit               in_taken = 1'b0;
  int               send_wait = 0;
  int               ready_wait = 0;
  int               in_flight = 0;
  int               words_queued = 0;
  int               mismatches = 0;
  int               quiet = 0;
  bit               in_calm = 1'b1;
  bit               out_calm = 1'b1;

  assign data_byte = cur_word.data;
  assign row_end   = cur_word.last;
  assign empty_row = cur_word.empty;

  row_substring_predicate_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .row_end    (row_end),
    .empty_row  (empty_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_match  (row_match),
    .row_number (row_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int needle_len(input int k);
    return int'(cfg_lens[4*k +: 4]);
  endfunction

  function automatic logic [7:0] needle_byte(input int k, input int j);
    return cfg_needle[k][8*j +: 8];
  endfunction

  function automatic int active_needles();
    return (cfg_count > NEEDLES) ? NEEDLES : int'(cfg_count);
  endfunction

  // True when needle k ends at the newest byte, using at most avail bytes.
  function automatic bit ends_with_needle(input int k, input int avail);
    int len, j;
    len = needle_len(k);
    if (len == 0 || len > NEEDLE_BYTES || avail < len) return 1'b0;
    for (j = 0; j < len; j++)
      if (needle_byte(k, j) != recent[len-1-j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void pass_empty_needles();
    while (stage < active_needles() && needle_len(stage) == 0) stage++;
  endfunction

  function automatic void clear_row();
    int k;
    for (k = 0; k < NEEDLE_BYTES; k++) recent[k] = 8'h00;
    row_len = 0;
    anchor_gap = 0;
    stage = 0;
    prefix_ok = 1'b1;
    hit = 1'b0;
  endfunction

  // Advances the mirror by one accepted word and records the row result it finishes.
  function automatic void judge_word(input word_t w);
    int n, len0, k;
    bit matched;
    rsp_pkg::result_t due;
    n = active_needles();
    len0 = needle_len(0);
    if (!w.empty) begin
      if (cfg_op == rsp_pkg::OP_PREFIX && row_len < len0 && row_len < NEEDLE_BYTES &&
          needle_byte(0, row_len) != w.data)
        prefix_ok = 1'b0;
      if (cfg_op == rsp_pkg::OP_ORDERED) pass_empty_needles();
      for (k = NEEDLE_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = w.data;
      if (row_len < NEEDLE_BYTES) row_len++;
      if (anchor_gap < NEEDLE_BYTES) anchor_gap++;
      if (cfg_op == rsp_pkg::OP_CONTAINS && ends_with_needle(0, row_len)) hit = 1'b1;
      if (cfg_op == rsp_pkg::OP_ANY)
        for (k = 0; k < n; k++)
          if (ends_with_needle(k, row_len)) hit = 1'b1;
      // The ordered search only looks at bytes after the previous hit.
      if (cfg_op == rsp_pkg::OP_ORDERED && stage < n &&
          ends_with_needle(stage, anchor_gap)) begin
        stage++;
        anchor_gap = 0;
      end
    end
    if (!w.empty && !w.last) return;
    case (cfg_op)
      rsp_pkg::OP_PREFIX:   matched = len0 <= NEEDLE_BYTES && prefix_ok && row_len >= len0;
      rsp_pkg::OP_SUFFIX:   matched = ends_with_needle(0, row_len) || len0 == 0;
      rsp_pkg::OP_CONTAINS: matched = hit || len0 == 0;
      rsp_pkg::OP_ORDERED: begin
        pass_empty_needles();
        matched = stage >= n;
      end
      rsp_pkg::OP_ANY: begin
        matched = hit;
        for (k = 0; k < n; k++)
          if (needle_len(k) == 0) matched = 1'b1;
      end
      default: matched = 1'b0;
    endcase
    due.row_match = matched;
    due.row_number = row_index;
    rows_due.push_back(due);
    row_index++;
    clear_row();
  endfunction

  task automatic set_reg(input logic [rsp_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      rsp_pkg::REG_OPERATION:      cfg_op = value[2:0];
      rsp_pkg::REG_NEEDLES_IN_USE: cfg_count = value[2:0];
      rsp_pkg::REG_NEEDLE_LENGTHS: cfg_lens = value[15:0];
      default:                     cfg_needle[2'(idx - rsp_pkg::REG_NEEDLE_ZERO)] = value;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_needle(input int k, input logic [63:0] value);
    logic [rsp_pkg::CFG_INDEX_W-1:0] idx;
    idx = rsp_pkg::CFG_INDEX_W'(int'(rsp_pkg::REG_NEEDLE_ZERO) + k);
    set_reg(idx, value);
  endtask

  task automatic queue_word(input logic [7:0] data, input logic last, input logic empty);
    word_t w;
    w.data = data;
    w.last = last;
    w.empty = empty;
    w.gap = in_calm ? 0 : $urandom_range(0, 19);
    words_to_send.push_back(w);
    in_flight++;
    words_queued++;
  endtask

  // Waits until every word is taken and every row result is back. The extra
  // cycles cover a word still inside the block that finishes no row.
  task automatic settle();
    while (in_flight != 0 || rows_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'h00;
      2:       return 8'hFF;
      3:       return 8'h41;
      default: return 8'h42;
    endcase
  endfunction

  function automatic logic [63:0] pick_needle();
    logic [63:0] v;
    int j;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = {$urandom, $urandom};
      default: for (j = 0; j < NEEDLE_BYTES; j++) v[8*j +: 8] = pick_byte();
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_lengths();
    logic [15:0] v;
    int k;
    case ($urandom_range(0, 9))
      0: v = 16'hFFFF;
      1: v = '0;
      default:
        for (k = 0; k < NEEDLES; k++) begin
          if ($urandom_range(0, 9) == 0) v[4*k +: 4] = 4'($urandom_range(9, 15));
          else if ($urandom_range(0, 3) == 0) v[4*k +: 4] = 4'($urandom_range(5, 8));
          else v[4*k +: 4] = 4'($urandom_range(0, 4));
        end
    endcase
    return v;
  endfunction

  task automatic shuffle_settings(input bit all);
    int k;
    if (all || $urandom_range(0, 1)) begin
      if ($urandom_range(0, 9) == 0)
        set_reg(rsp_pkg::REG_OPERATION,
                64'($urandom_range(rsp_pkg::OP_ANY + 1, OP_CODE_LAST)));
      else
        set_reg(rsp_pkg::REG_OPERATION,
                64'($urandom_range(rsp_pkg::OP_PREFIX, rsp_pkg::OP_ANY)));
    end
    if (all || $urandom_range(0, 1))
      set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'($urandom_range(0, 7)));
    if (all || $urandom_range(0, 1))
      set_reg(rsp_pkg::REG_NEEDLE_LENGTHS, 64'(pick_lengths()));
    for (k = 0; k < NEEDLES; k++)
      if (all || $urandom_range(0, 2) == 0) set_needle(k, pick_needle());
  endtask

  // A row built partly from needle copies and partly from picked bytes, so that hits are common.
  task automatic queue_row();
    logic [7:0] row_bytes [$];
    int target, k, j, n;
    target = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    while (row_bytes.size() < target) begin
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, NEEDLES - 1);
        n = needle_len(k);
        if (n > NEEDLE_BYTES) n = NEEDLE_BYTES;
        for (j = 0; j < n; j++) row_bytes.push_back(needle_byte(k, j));
      end else begin
        row_bytes.push_back(pick_byte());
      end
    end
    if (row_bytes.size() == 0) begin
      queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      for (j = 0; j < row_bytes.size() - 1; j++) queue_word(row_bytes[j], 1'b0, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        queue_word(row_bytes[row_bytes.size() - 1], 1'b0, 1'b0);
        queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        queue_word(row_bytes[row_bytes.size() - 1], 1'b1, 1'b0);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (words_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_wait < words_to_send[0].gap) begin
        send_wait++;
        in_valid <= 1'b0;
      end else begin
        cur_word = words_to_send.pop_front();
        send_wait = 0;
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= (ready_wait == 0);
    if (out_valid && ready_wait > 0) ready_wait--;
  end

  always @(posedge clk) begin
    rsp_pkg::result_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        ready_wait = out_calm ? 0 : $urandom_range(0, 19);
        if (rows_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected row word: match %0b number %0d", row_match, row_number);
          mismatches++;
        end else begin
          due = rows_due.pop_front();
          if (row_match !== due.row_match || row_number !== due.row_number) begin
            if (mismatches < REPORT_LIMIT)
              $display("row %0d: expected match %0b number %0d, got match %0b number %0d",
                       due.row_number, due.row_match, due.row_number, row_match, row_number);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        judge_word(cur_word);
        in_taken = 1'b1;
        in_flight--;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int word_goal;
    bit all_regs;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_op = rsp_pkg::OP_CONTAINS;
    cfg_count = 3'd1;
    cfg_lens = '0;
    for (int k = 0; k < NEEDLES; k++) cfg_needle[k] = '0;
    clear_row();
    row_index = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset needle 0 is empty, so an empty row already matches.
    queue_word(8'h00, 1'b1, 1'b1);
    settle();

    // Needle 0 is FF 00, needle 1 is 41, needle 2 is empty, needle 3 is too long.
    set_reg(rsp_pkg::REG_OPERATION, 64'(rsp_pkg::OP_PREFIX));
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd2);
    set_reg(rsp_pkg::REG_NEEDLE_LENGTHS, 64'h9012);
    set_needle(0, 64'hA5A5_A5A5_A5A5_00FF);
    set_needle(1, 64'h5A5A_5A5A_5A5A_5A41);
    set_needle(2, '1);
    set_needle(3, '0);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'h7E, 1'b1, 1'b0);
    queue_word(8'hFF, 1'b1, 1'b0);
    settle();

    set_reg(rsp_pkg::REG_OPERATION, 64'(rsp_pkg::OP_SUFFIX));
    queue_word(8'h41, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b0);
    // Leave a row open, switch to contains, then close it with an empty-row mark.
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    settle();
    set_reg(rsp_pkg::REG_OPERATION, 64'(rsp_pkg::OP_CONTAINS));
    queue_word(8'h41, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b1);
    queue_word(8'h41, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'h41, 1'b1, 1'b0);
    settle();

    set_reg(rsp_pkg::REG_OPERATION, 64'(rsp_pkg::OP_ORDERED));
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd3);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'h41, 1'b1, 1'b0);
    settle();
    // A count above the needle total acts as four; an empty row stops at the first needle.
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd7);
    queue_word(8'h00, 1'b0, 1'b1);
    settle();
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd0);
    queue_word(8'hFF, 1'b0, 1'b1);
    settle();

    set_reg(rsp_pkg::REG_OPERATION, 64'(rsp_pkg::OP_ANY));
    queue_word(8'h41, 1'b1, 1'b0);
    settle();
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd2);
    queue_word(8'h7E, 1'b0, 1'b0);
    queue_word(8'h41, 1'b1, 1'b0);
    settle();
    set_reg(rsp_pkg::REG_NEEDLES_IN_USE, 64'd3);
    queue_word(8'h00, 1'b0, 1'b1);
    settle();
    set_reg(rsp_pkg::REG_OPERATION, 64'(OP_CODE_LAST));
    queue_word(8'h41, 1'b1, 1'b0);
    settle();

    word_goal = words_queued + RANDOM_WORDS;
    all_regs = 1'b1;
    while (words_queued < word_goal) begin
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      shuffle_settings(all_regs);
      all_regs = 1'b0;
      repeat ($urandom_range(5, 15)) queue_row();
      // Sometimes the phase ends inside a row, so the next settings apply mid row.
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 5)) queue_word(pick_byte(), 1'b0, 1'b0);
      settle();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && rows_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
